/* design/tldn_pkg.sv */
// Shared types and constants for the day/night traffic light controller.
// Used by the configuration channel interface, the step logic and the top level.
// No dependencies.
`default_nettype none

package tldn_pkg;

    // Widths of the configuration port and the stored counters
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 8;
    localparam int COUNT_W     = 9;
    localparam int PHASE_W     = 10;

    // Value of every configuration register after reset
    localparam logic [CFG_DATA_W-1:0] CFG_RESET = 8'd10;

    // Saturation point of the dark and bright run counters
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // Register indexes on the configuration port
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_DARK_LIMIT   = 3'd0,
        REG_LIGHT_LIMIT  = 3'd1,
        REG_HOLD_TICKS   = 3'd2,
        REG_YELLOW_TICKS = 3'd3,
        REG_WALK_TICKS   = 3'd4,
        REG_FLASH_TICKS  = 3'd5
    } cfg_index_t;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] dark_limit;
        logic [CFG_DATA_W-1:0] light_limit;
        logic [CFG_DATA_W-1:0] hold_ticks;
        logic [CFG_DATA_W-1:0] yellow_ticks;
        logic [CFG_DATA_W-1:0] walk_ticks;
        logic [CFG_DATA_W-1:0] flash_ticks;
    } cfg_t;

    typedef struct packed {
        logic car_g;
        logic car_y;
        logic car_r;
        logic walk_g;
        logic walk_r;
    } lamp_t;

    typedef struct packed {
        logic               night;
        logic               bright_flag;
        logic               walk_pending;
        logic [COUNT_W-1:0] dark_count;
        logic [COUNT_W-1:0] bright_count;
        logic [PHASE_W-1:0] phase_count;
        lamp_t              lamps;
    } ctrl_state_t;

    // State left by reset
    localparam ctrl_state_t STATE_RESET = '{
        night:        1'b0,
        bright_flag:  1'b1,
        walk_pending: 1'b0,
        dark_count:   '0,
        bright_count: '0,
        phase_count:  '0,
        lamps:        '{car_g: 1'b1, car_y: 1'b0, car_r: 1'b0, walk_g: 1'b1, walk_r: 1'b0}
    };

endpackage

`default_nettype wire

/* design/tldn_sample_if.sv */
// Input channel: one sensor/button sample per transfer.
// No dependencies.
`default_nettype none

interface tldn_sample_if;
    logic valid;
    logic ready;
    logic sensor_dark;
    logic button_level;

    modport source (output valid, output sensor_dark, output button_level, input ready);
    modport sink   (input valid, input sensor_dark, input button_level, output ready);
endinterface

`default_nettype wire

/* design/tldn_lamps_if.sv */
// Output channel: lamp pin levels and period after one tick.
// No dependencies.
`default_nettype none

interface tldn_lamps_if;
    logic valid;
    logic ready;
    logic car_green_pin;
    logic car_yellow_pin;
    logic car_red_pin;
    logic walker_green_pin;
    logic walker_red_pin;
    logic night_mode;

    modport source (
        output valid, output car_green_pin, output car_yellow_pin, output car_red_pin,
        output walker_green_pin, output walker_red_pin, output night_mode, input ready
    );
    modport sink (
        input valid, input car_green_pin, input car_yellow_pin, input car_red_pin,
        input walker_green_pin, input walker_red_pin, input night_mode, output ready
    );
endinterface

`default_nettype wire

/* design/tldn_cfg_if.sv */
// Configuration write channel: register index and write data.
// Depends on tldn_pkg for the index and data widths.
`default_nettype none

interface tldn_cfg_if;
    import tldn_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* design/tldn_step.sv */
// Next-state logic for one tick: day walk sequencing, night blinking and
// the dark/bright run counters. Depends on tldn_pkg.
`default_nettype none

module tldn_step (
    input  tldn_pkg::ctrl_state_t cur,
    input  tldn_pkg::cfg_t        cfg,
    input  logic                  sensor_dark,
    input  logic                  button_level,
    output tldn_pkg::ctrl_state_t nxt
);
    import tldn_pkg::*;

    logic [PHASE_W-1:0] t1;
    logic [PHASE_W-1:0] t2;
    logic [PHASE_W-1:0] t3;
    logic [PHASE_W-1:0] t4;

    // Phase bounds of the walk cycle
    assign t1 = PHASE_W'(cfg.hold_ticks);
    assign t2 = t1 + PHASE_W'(cfg.yellow_ticks);
    assign t3 = t2 + PHASE_W'(cfg.walk_ticks);
    assign t4 = t3 + PHASE_W'(cfg.flash_ticks);

    always_comb
    begin
        ctrl_state_t        n;
        logic [COUNT_W-1:0] cnt;
        logic               pend;

        n    = cur;
        cnt  = '0;
        pend = 1'b0;

        if (!cur.night)
        begin
            // Track the dark run and drop the bright flag past the limit
            if (sensor_dark)
            begin
                cnt = cur.dark_count;
                if (cnt != COUNT_MAX)
                begin
                    cnt = cnt + COUNT_W'(1);
                end
                if (cnt > COUNT_W'(cfg.dark_limit))
                begin
                    n.bright_flag = 1'b0;
                end
            end
            n.dark_count = cnt;

            if (cur.lamps.car_g && !cur.walk_pending && !n.bright_flag)
            begin
                // Enter night: car yellow, walker green
                n.dark_count   = '0;
                n.night        = 1'b1;
                n.lamps        = '{car_g: 1'b0, car_y: 1'b1, car_r: 1'b0,
                                   walk_g: 1'b1, walk_r: 1'b0};
            end
            else
            begin
                pend = cur.walk_pending || (cur.lamps.car_g && button_level);
                n.walk_pending = pend;
                if (pend)
                begin
                    // Advance the walk cycle
                    if (cur.phase_count < t1)
                    begin
                        n.phase_count = cur.phase_count + PHASE_W'(1);
                    end
                    else if (cur.phase_count < t2)
                    begin
                        if (cur.phase_count == t1)
                        begin
                            n.lamps.car_g = 1'b0;
                            n.lamps.car_y = 1'b1;
                            n.lamps.car_r = 1'b0;
                        end
                        n.phase_count = cur.phase_count + PHASE_W'(1);
                    end
                    else if (cur.phase_count < t3)
                    begin
                        if (cur.phase_count == t2)
                        begin
                            n.lamps = '{car_g: 1'b0, car_y: 1'b0, car_r: 1'b1,
                                        walk_g: 1'b0, walk_r: 1'b1};
                        end
                        n.phase_count = cur.phase_count + PHASE_W'(1);
                    end
                    else if (cur.phase_count < t4)
                    begin
                        if (cur.phase_count == t3)
                        begin
                            n.lamps.walk_g = 1'b1;
                            n.lamps.walk_r = 1'b0;
                        end
                        else
                        begin
                            n.lamps.walk_r = !cur.lamps.walk_r;
                        end
                        n.phase_count = cur.phase_count + PHASE_W'(1);
                    end
                    else
                    begin
                        // End of walk: back to car green
                        n.lamps        = '{car_g: 1'b1, car_y: 1'b0, car_r: 1'b0,
                                           walk_g: 1'b1, walk_r: 1'b0};
                        n.phase_count  = '0;
                        n.walk_pending = 1'b0;
                    end
                end
            end
        end
        else
        begin
            // Night: count the bright run and leave night past the limit, else blink
            if (!sensor_dark)
            begin
                cnt = cur.bright_count;
                if (cnt != COUNT_MAX)
                begin
                    cnt = cnt + COUNT_W'(1);
                end
            end
            n.bright_count = cnt;
            if (!sensor_dark && cnt > COUNT_W'(cfg.light_limit))
            begin
                n.bright_count = '0;
                n.night        = 1'b0;
                n.bright_flag  = 1'b1;
                n.lamps        = '{car_g: 1'b1, car_y: 1'b0, car_r: 1'b0,
                                   walk_g: 1'b1, walk_r: 1'b0};
            end
            else
            begin
                n.lamps.walk_r = !cur.lamps.walk_r;
                n.lamps.car_y  = !cur.lamps.car_y;
            end
        end

        nxt = n;
    end

endmodule

`default_nettype wire

/* design/traffic_light_day_night_controller_unit.sv */
// Top level of the day/night traffic light controller with pedestrian button.
// Depends on tldn_pkg, the three channel interfaces and tldn_step.
//
//   channel | direction | payload                                   | handshake
//   sample  | sink      | sensor_dark, button_level                 | valid/ready
//   lamps   | source    | car_green/yellow/red, walker_green/red,   | valid/ready
//           |           | night_mode pins                           |
//   cfg     | sink      | index (3 bits), data (8 bits)             | valid/ready
//
// One tick per cycle sustained while the result side is ready: a sample sits in
// the input register, and the step logic updates the controller state and the
// result register when the sample advances. A sample passes the input register
// and then the result register before its result can transfer.
// Reset (rst_n low, asynchronous) restores every configuration register to 10,
// car green and walker green lit, day period. A stalled result holds the input
// stage; configuration writes are taken every cycle.
`default_nettype none

module traffic_light_day_night_controller_unit (
    input  logic         clk,
    input  logic         rst_n,
    tldn_sample_if.sink  sample,
    tldn_lamps_if.source lamps,
    tldn_cfg_if.sink     cfg
);
    import tldn_pkg::*;

    cfg_t        cfg_reg;
    logic        in_valid_reg;
    logic        in_dark_reg;
    logic        in_button_reg;
    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        out_valid_reg;
    lamp_t       out_lamps_reg;
    logic        out_night_reg;
    logic        advance;

    // Configuration registers
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{CFG_RESET, CFG_RESET, CFG_RESET, CFG_RESET, CFG_RESET, CFG_RESET};
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_DARK_LIMIT:   cfg_reg.dark_limit   <= cfg.data;
                REG_LIGHT_LIMIT:  cfg_reg.light_limit  <= cfg.data;
                REG_HOLD_TICKS:   cfg_reg.hold_ticks   <= cfg.data;
                REG_YELLOW_TICKS: cfg_reg.yellow_ticks <= cfg.data;
                REG_WALK_TICKS:   cfg_reg.walk_ticks   <= cfg.data;
                REG_FLASH_TICKS:  cfg_reg.flash_ticks  <= cfg.data;
                default:          ;
            endcase
        end
    end

    // Move a held sample into the result stage when that stage is free
    assign advance      = in_valid_reg && (!out_valid_reg || lamps.ready);
    assign sample.ready = !in_valid_reg || advance;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (sample.ready)
        begin
            in_valid_reg <= sample.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample.valid && sample.ready)
        begin
            in_dark_reg   <= sample.sensor_dark;
            in_button_reg <= sample.button_level;
        end
    end

    tldn_step u_step (
        .cur          (state_reg),
        .cfg          (cfg_reg),
        .sensor_dark  (in_dark_reg),
        .button_level (in_button_reg),
        .nxt          (state_next)
    );

    // Controller state and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= STATE_RESET;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            state_reg     <= state_next;
            out_valid_reg <= 1'b1;
        end
        else if (lamps.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_lamps_reg <= state_next.lamps;
            out_night_reg <= state_next.night;
        end
    end

    assign lamps.valid            = out_valid_reg;
    assign lamps.car_green_pin    = out_lamps_reg.car_g;
    assign lamps.car_yellow_pin   = out_lamps_reg.car_y;
    assign lamps.car_red_pin      = out_lamps_reg.car_r;
    assign lamps.walker_green_pin = out_lamps_reg.walk_g;
    assign lamps.walker_red_pin   = out_lamps_reg.walk_r;
    assign lamps.night_mode       = out_night_reg;

    // No walk runs at night
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.night |-> !state_reg.walk_pending)
        else $error("walk pending during night period");

    // The phase counter rests at zero outside a walk
    assert property (@(posedge clk) disable iff (!rst_n)
        !state_reg.walk_pending |-> (state_reg.phase_count == '0))
        else $error("phase counter nonzero with no walk pending");

    // By day exactly one car lamp is lit
    assert property (@(posedge clk) disable iff (!rst_n)
        !state_reg.night |->
            $onehot({state_reg.lamps.car_g, state_reg.lamps.car_y, state_reg.lamps.car_r}))
        else $error("car lamps not one-hot by day");

    // A result is only loaded from a held sample
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(in_valid_reg))
        else $error("result produced without a sample");

endmodule

`default_nettype wire

/* sim/testbench.sv */
// Testbench for the day/night traffic light controller: directed table, then random
// phases, each result checked against a typed expectation or a cycle-free predictor.
// Depends on tldn_pkg, the three channel interfaces and the controller top level.
`default_nettype none

module testbench;
    import tldn_pkg::*;

    // Indexes past the last register; writes there must be ignored
    localparam logic [CFG_INDEX_W-1:0] REG_PAST_END_LO = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_PAST_END_HI = 3'd7;

    localparam int MAX_SHOWN   = 30;
    localparam int DRAIN_PAD   = 10;
    localparam int NUM_PHASES  = 12;

    typedef struct packed {
        lamp_t lamps;
        logic  night;
    } tick_result_t;

    typedef enum logic {ROW_TICK, ROW_CFG} row_kind_t;

    typedef struct packed {
        row_kind_t              kind;
        logic [CFG_INDEX_W-1:0] index;
        logic [CFG_DATA_W-1:0]  data;
        logic                   dark;
        logic                   button;
        logic                   typed;
        tick_result_t           want;
    } plan_row_t;

    // Lamp patterns that can be read straight off the spec
    localparam tick_result_t DAY_GREEN = '{
        lamps: '{car_g: 1'b1, car_y: 1'b0, car_r: 1'b0, walk_g: 1'b1, walk_r: 1'b0},
        night: 1'b0
    };
    localparam tick_result_t NIGHT_ENTRY = '{
        lamps: '{car_g: 1'b0, car_y: 1'b1, car_r: 1'b0, walk_g: 1'b1, walk_r: 1'b0},
        night: 1'b1
    };

    logic clk;
    logic rst_n;

    tldn_sample_if sample_ch ();
    tldn_lamps_if  lamps_ch ();
    tldn_cfg_if    cfg_ch ();

    traffic_light_day_night_controller_unit uut (
        .clk   (clk),
        .rst_n (rst_n),
        .sample(sample_ch),
        .lamps (lamps_ch),
        .cfg   (cfg_ch)
    );

    // Predictor state and register shadow
    ctrl_state_t  lights_state;
    cfg_t         timing_cfg;
    tick_result_t lamps_due[$];

    int  mismatches;
    int  results_seen;
    int  ticks_sent;
    int  directed_ticks;
    int  walks_started;
    int  nights_entered;
    int  phases_run;
    int  stall_left;
    bit  idle_on;

    plan_row_t directed_plan[$];

    // Free-running clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Hard limit on the run
    initial
    begin
        #5000000;
        $display("Regression FAIL");
        $finish;
    end

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= MAX_SHOWN)
            $display("MISMATCH at %0t: %s", $time, what);
    endtask

    task automatic check_pin(input string name, input logic got, input logic want);
        if (got !== want)
            report_mismatch($sformatf("result %0d %s got %b want %b",
                                      results_seen, name, got, want));
    endtask

    // Gap length: mostly short, now and then long
    function automatic int pick_gap_len();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Advance the predicted controller by one tick and return the lamp levels
    function automatic tick_result_t step_lamps(input logic dark, input logic button);
        int           t1, t2, t3, t4, ph;
        logic         to_day;
        tick_result_t res;
        to_day = 1'b0;
        if (lights_state.night) begin
            if (!dark) begin
                if (lights_state.bright_count != COUNT_MAX)
                    lights_state.bright_count = lights_state.bright_count + COUNT_W'(1);
                to_day = int'(lights_state.bright_count) > int'(timing_cfg.light_limit);
            end
            else begin
                lights_state.bright_count = '0;
            end
            if (to_day) begin
                lights_state.bright_count = '0;
                lights_state.night        = 1'b0;
                lights_state.bright_flag  = 1'b1;
                lights_state.lamps        = DAY_GREEN.lamps;
            end
            else begin
                lights_state.lamps.walk_r = ~lights_state.lamps.walk_r;
                lights_state.lamps.car_y  = ~lights_state.lamps.car_y;
            end
        end
        else begin
            // Track the dark run; a long one clears the bright flag until night ends
            if (dark) begin
                if (lights_state.dark_count != COUNT_MAX)
                    lights_state.dark_count = lights_state.dark_count + COUNT_W'(1);
                if (int'(lights_state.dark_count) > int'(timing_cfg.dark_limit))
                    lights_state.bright_flag = 1'b0;
            end
            else begin
                lights_state.dark_count = '0;
            end

            if (lights_state.lamps.car_g && !lights_state.walk_pending &&
                !lights_state.bright_flag) begin
                lights_state.dark_count = '0;
                lights_state.night      = 1'b1;
                lights_state.lamps      = NIGHT_ENTRY.lamps;
                nights_entered++;
            end
            else begin
                if (lights_state.lamps.car_g && !lights_state.walk_pending && button) begin
                    lights_state.walk_pending = 1'b1;
                    walks_started++;
                end
                if (lights_state.walk_pending) begin
                    ph = int'(lights_state.phase_count);
                    t1 = int'(timing_cfg.hold_ticks);
                    t2 = t1 + int'(timing_cfg.yellow_ticks);
                    t3 = t2 + int'(timing_cfg.walk_ticks);
                    t4 = t3 + int'(timing_cfg.flash_ticks);
                    if (ph < t4) begin
                        if (ph >= t1 && ph < t2 && ph == t1) begin
                            lights_state.lamps.car_g = 1'b0;
                            lights_state.lamps.car_y = 1'b1;
                            lights_state.lamps.car_r = 1'b0;
                        end
                        else if (ph >= t2 && ph < t3 && ph == t2) begin
                            lights_state.lamps.car_g  = 1'b0;
                            lights_state.lamps.car_y  = 1'b0;
                            lights_state.lamps.car_r  = 1'b1;
                            lights_state.lamps.walk_g = 1'b0;
                            lights_state.lamps.walk_r = 1'b1;
                        end
                        else if (ph >= t3) begin
                            if (ph == t3) begin
                                lights_state.lamps.walk_g = 1'b1;
                                lights_state.lamps.walk_r = 1'b0;
                            end
                            else begin
                                lights_state.lamps.walk_r = ~lights_state.lamps.walk_r;
                            end
                        end
                        lights_state.phase_count = lights_state.phase_count + PHASE_W'(1);
                    end
                    else begin
                        lights_state.lamps        = DAY_GREEN.lamps;
                        lights_state.phase_count  = '0;
                        lights_state.walk_pending = 1'b0;
                    end
                end
            end
        end
        res.lamps = lights_state.lamps;
        res.night = lights_state.night;
        return res;
    endfunction

    function automatic plan_row_t tick_row(input logic dark, input logic button);
        plan_row_t r;
        r        = '0;
        r.kind   = ROW_TICK;
        r.dark   = dark;
        r.button = button;
        return r;
    endfunction

    function automatic plan_row_t known_row(input logic dark, input logic button,
                                            input tick_result_t want);
        plan_row_t r;
        r       = tick_row(dark, button);
        r.typed = 1'b1;
        r.want  = want;
        return r;
    endfunction

    function automatic plan_row_t cfg_row(input logic [CFG_INDEX_W-1:0] index,
                                          input logic [CFG_DATA_W-1:0] data);
        plan_row_t r;
        r       = '0;
        r.kind  = ROW_CFG;
        r.index = index;
        r.data  = data;
        return r;
    endfunction

    // Drop the sample valid and wait until every expected result is back
    task automatic wait_drained();
        sample_ch.valid <= 1'b0;
        @(posedge clk);
        while (lamps_due.size() != 0)
            @(posedge clk);
    endtask

    // Write one register while the controller is idle
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] data);
        wait_drained();
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= index;
        cfg_ch.data  <= data;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        case (index)
            REG_DARK_LIMIT:   timing_cfg.dark_limit   = data;
            REG_LIGHT_LIMIT:  timing_cfg.light_limit  = data;
            REG_HOLD_TICKS:   timing_cfg.hold_ticks   = data;
            REG_YELLOW_TICKS: timing_cfg.yellow_ticks = data;
            REG_WALK_TICKS:   timing_cfg.walk_ticks   = data;
            REG_FLASH_TICKS:  timing_cfg.flash_ticks  = data;
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic apply_settings(input cfg_t s);
        write_reg(REG_DARK_LIMIT,   s.dark_limit);
        write_reg(REG_LIGHT_LIMIT,  s.light_limit);
        write_reg(REG_HOLD_TICKS,   s.hold_ticks);
        write_reg(REG_YELLOW_TICKS, s.yellow_ticks);
        write_reg(REG_WALK_TICKS,   s.walk_ticks);
        write_reg(REG_FLASH_TICKS,  s.flash_ticks);
    endtask

    // Send one tick after an optional gap; queue its expected lamps on transfer
    task automatic send_tick(input logic dark, input logic button,
                             input logic typed, input tick_result_t want);
        int           gap;
        tick_result_t predicted;
        gap = 0;
        if (idle_on && $urandom_range(0, 3) == 0)
            gap = pick_gap_len();
        if (gap != 0) begin
            sample_ch.valid <= 1'b0;
            repeat (gap)
            begin
                sample_ch.sensor_dark  <= ($urandom_range(0, 1) != 0);
                sample_ch.button_level <= ($urandom_range(0, 1) != 0);
                @(posedge clk);
            end
        end
        sample_ch.valid        <= 1'b1;
        sample_ch.sensor_dark  <= dark;
        sample_ch.button_level <= button;
        do
            @(posedge clk);
        while (!sample_ch.ready);
        predicted = step_lamps(dark, button);
        lamps_due.push_back(typed ? want : predicted);
        ticks_sent++;
    endtask

    // Runs of equal sensor level with random button presses
    task automatic run_phase(input int count, input int dark_pct, input int run_max,
                             input int button_pct);
        int   left;
        int   len;
        logic level;
        left = count;
        while (left > 0) begin
            level = ($urandom_range(0, 99) < dark_pct);
            len   = $urandom_range(1, run_max);
            if (len > left)
                len = left;
            repeat (len)
                send_tick(level, ($urandom_range(0, 99) < button_pct), 1'b0, '0);
            left -= len;
        end
    endtask

    // Result side: random stalls, compare each transfer with the oldest expectation
    initial
    begin
        tick_result_t got;
        tick_result_t want;
        lamps_ch.ready = 1'b0;
        stall_left     = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && lamps_ch.valid && lamps_ch.ready) begin
                got.lamps.car_g  = lamps_ch.car_green_pin;
                got.lamps.car_y  = lamps_ch.car_yellow_pin;
                got.lamps.car_r  = lamps_ch.car_red_pin;
                got.lamps.walk_g = lamps_ch.walker_green_pin;
                got.lamps.walk_r = lamps_ch.walker_red_pin;
                got.night        = lamps_ch.night_mode;
                if (lamps_due.size() == 0) begin
                    report_mismatch("lamp result with nothing expected");
                end
                else begin
                    want = lamps_due.pop_front();
                    check_pin("car_green_pin",    got.lamps.car_g,  want.lamps.car_g);
                    check_pin("car_yellow_pin",   got.lamps.car_y,  want.lamps.car_y);
                    check_pin("car_red_pin",      got.lamps.car_r,  want.lamps.car_r);
                    check_pin("walker_green_pin", got.lamps.walk_g, want.lamps.walk_g);
                    check_pin("walker_red_pin",   got.lamps.walk_r, want.lamps.walk_r);
                    check_pin("night_mode",       got.night,        want.night);
                end
                results_seen++;
            end
            // Hold off the result side now and then
            if (stall_left > 0) begin
                lamps_ch.ready <= 1'b0;
                stall_left--;
            end
            else begin
                lamps_ch.ready <= 1'b1;
                if (idle_on && $urandom_range(0, 7) == 0)
                    stall_left = pick_gap_len();
            end
        end
    end

    // Main sequence
    initial
    begin
        cfg_t s;
        int   phase;
        int   run_max;

        rst_n                  = 1'b0;
        sample_ch.valid        = 1'b0;
        sample_ch.sensor_dark  = 1'b0;
        sample_ch.button_level = 1'b0;
        cfg_ch.valid           = 1'b0;
        cfg_ch.index           = REG_DARK_LIMIT;
        cfg_ch.data            = '0;
        idle_on                = 1'b1;
        mismatches             = 0;
        results_seen           = 0;
        ticks_sent             = 0;
        walks_started          = 0;
        nights_entered         = 0;
        phases_run             = 0;
        lights_state           = STATE_RESET;
        timing_cfg             = '{CFG_RESET, CFG_RESET, CFG_RESET,
                                   CFG_RESET, CFG_RESET, CFG_RESET};

        directed_plan = '{
            // idle tick right after reset
            known_row(1'b0, 1'b0, DAY_GREEN),
            // short walk phases, low thresholds, writes past the last register
            cfg_row(REG_HOLD_TICKS, 8'd1),
            cfg_row(REG_YELLOW_TICKS, 8'd1),
            cfg_row(REG_WALK_TICKS, 8'd1),
            cfg_row(REG_FLASH_TICKS, 8'd2),
            cfg_row(REG_DARK_LIMIT, 8'd1),
            cfg_row(REG_LIGHT_LIMIT, 8'd1),
            cfg_row(REG_PAST_END_LO, 8'h00),
            cfg_row(REG_PAST_END_HI, 8'hFF),
            // full walk: press, hold, yellow, red, walker green, flash, back to green
            tick_row(1'b0, 1'b1),
            tick_row(1'b0, 1'b0),
            tick_row(1'b0, 1'b0),
            tick_row(1'b0, 1'b0),
            tick_row(1'b0, 1'b0),
            known_row(1'b0, 1'b0, DAY_GREEN),
            // two dark ticks exceed a limit of one; a press then is ignored
            tick_row(1'b1, 1'b0),
            known_row(1'b1, 1'b1, NIGHT_ENTRY),
            // night blink; a dark tick clears the bright run
            tick_row(1'b0, 1'b0),
            tick_row(1'b1, 1'b0),
            tick_row(1'b0, 1'b0),
            known_row(1'b0, 1'b1, DAY_GREEN),
            // empty hold, yellow and walk phases
            cfg_row(REG_DARK_LIMIT, 8'd0),
            cfg_row(REG_HOLD_TICKS, 8'd0),
            cfg_row(REG_YELLOW_TICKS, 8'd0),
            cfg_row(REG_WALK_TICKS, 8'd0),
            cfg_row(REG_FLASH_TICKS, 8'd1),
            tick_row(1'b0, 1'b1),
            known_row(1'b0, 1'b0, DAY_GREEN),
            // shrink the walk while it runs so the next tick ends it
            cfg_row(REG_HOLD_TICKS, 8'd2),
            cfg_row(REG_YELLOW_TICKS, 8'd5),
            cfg_row(REG_WALK_TICKS, 8'd5),
            tick_row(1'b0, 1'b1),
            tick_row(1'b0, 1'b0),
            tick_row(1'b0, 1'b0),
            cfg_row(REG_YELLOW_TICKS, 8'd0),
            cfg_row(REG_WALK_TICKS, 8'd0),
            known_row(1'b0, 1'b0, DAY_GREEN),
            // dark limit zero: one dark tick is enough
            known_row(1'b1, 1'b0, NIGHT_ENTRY)
        };

        // Reset once
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table
        foreach (directed_plan[i])
        begin
            if (directed_plan[i].kind == ROW_CFG)
                write_reg(directed_plan[i].index, directed_plan[i].data);
            else
                send_tick(directed_plan[i].dark, directed_plan[i].button,
                          directed_plan[i].typed, directed_plan[i].want);
        end
        directed_ticks = ticks_sent;

        // Random phases, each under its own settings
        for (phase = 0; phase < NUM_PHASES; phase++)
        begin
            idle_on = (phase % 4 != 3);
            case (phase)
                0: begin
                    // instant darkness, very long bright run needed to leave night
                    s = '{8'd0, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255};
                    apply_settings(s);
                    run_phase(200, 10, 300, 30);
                end
                6: begin
                    // every register at its top value
                    s = '{8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255};
                    apply_settings(s);
                    run_phase(260, 90, 300, 30);
                end
                default: begin
                    s.dark_limit   = CFG_DATA_W'($urandom_range(0, 12));
                    s.light_limit  = CFG_DATA_W'($urandom_range(0, 12));
                    s.hold_ticks   = CFG_DATA_W'($urandom_range(0, 6));
                    s.yellow_ticks = CFG_DATA_W'($urandom_range(0, 6));
                    s.walk_ticks   = CFG_DATA_W'($urandom_range(0, 6));
                    s.flash_ticks  = CFG_DATA_W'($urandom_range(0, 6));
                    apply_settings(s);
                    run_max = $urandom_range(2, 16);
                    run_phase(50, 50, run_max, 25);
                end
            endcase
            phases_run++;
        end

        // Drain and let the pipeline settle
        wait_drained();
        repeat (DRAIN_PAD) @(posedge clk);
        if (lamps_due.size() != 0)
            report_mismatch($sformatf("%0d lamp results never arrived", lamps_due.size()));

        $display("Sent %0d ticks (%0d from the directed table) over %0d settings phases.",
                 ticks_sent, directed_ticks, phases_run);
        $display("Predicted %0d walk cycles and %0d switches to night; %0d mismatches.",
                 walks_started, nights_entered, mismatches);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

`default_nettype wire

/* filelist.f */
design/tldn_pkg.sv
design/tldn_sample_if.sv
design/tldn_lamps_if.sv
design/tldn_cfg_if.sv
design/tldn_step.sv
design/traffic_light_day_night_controller_unit.sv
sim/testbench.sv
